// File: rtl/core/cdbl_pkg.sv
`default_nettype none
package cdbl_pkg;

  // Action codes carried by an input item.
  localparam logic [1:0] ACT_STORE  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // Lookup status codes.
  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_MISSING = 2'd1,
    ST_CORRUPT = 2'd2,
    ST_TOOLONG = 2'd3
  } status_t;

  // Width of the image length register and of bounded sizes.
  localparam int LEN_W = 17;
  // Width of internal byte address arithmetic (table end can reach nine times the image).
  localparam int XW = 21;

  localparam logic [31:0]      HASH_START   = 32'd5381;
  localparam logic [LEN_W-1:0] HEADER_BYTES = 17'd2048;
  localparam logic [LEN_W-1:0] LEN_RESET    = 17'd2048;

  typedef struct packed {
    status_t     status;
    logic [15:0] value_offset;
    logic [15:0] value_length;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/cdbl_ifs.sv
`default_nettype none
// Request channel: one item per store, append or lookup action.
interface cdbl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  data_byte;
  modport source(output valid, action, address, data_byte, input ready);
  modport sink(input valid, action, address, data_byte, output ready);
endinterface

// Response channel: one item per lookup.
interface cdbl_rsp_if;
  logic                 valid;
  logic                 ready;
  cdbl_pkg::status_t    status;
  logic [15:0]          value_offset;
  logic [15:0]          value_length;
  modport source(output valid, status, value_offset, value_length, input ready);
  modport sink(input valid, status, value_offset, value_length, output ready);
endinterface

// Configuration channel: writes the image length register.
interface cdbl_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cdbl_div.sv
`default_nettype none
module cdbl_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [16:0] rem
);
  import cdbl_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [23:0] quo;
  logic [16:0] dvs;
  logic [17:0] trial;

  // One restoring step per cycle: shift in the next dividend bit.
  assign trial = {rem, quo[23]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        quo <= {quo[22:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          rem <= 17'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[16:0];
        end
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/cdbl_key.sv
`default_nettype none
module cdbl_key #(
  parameter int MAX_KEY = 64,
  localparam int KCW = $clog2(MAX_KEY + 1),
  localparam int KAW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           append,
  input  logic           clear,
  input  logic [7:0]     byte_in,
  input  logic [KAW-1:0] rd_idx,
  output logic [7:0]     rd_data,
  output logic [KCW-1:0] count,
  output logic           overflow,
  output logic [31:0]    hash
);
  import cdbl_pkg::*;

  logic [7:0] kmem [MAX_KEY];
  logic       room;

  assign room = count < KCW'(MAX_KEY);

  // Key count, overflow flag and running hash h = h*33 xor byte.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count    <= '0;
      overflow <= 1'b0;
      hash     <= HASH_START;
    end else if (append) begin
      if (room) begin
        count <= count + KCW'(1);
        hash  <= ((hash << 5) + hash) ^ {24'd0, byte_in};
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // Key byte buffer with a registered read port.
  always_ff @(posedge clk) begin
    if (append && room && !clear) begin
      kmem[count[KAW-1:0]] <= byte_in;
    end
    rd_data <= kmem[rd_idx];
  end

endmodule
`default_nettype wire

// File: rtl/core/cdbl_engine.sv
`default_nettype none
module cdbl_engine #(
  parameter int DB_BYTES = 65536,
  parameter int MAX_KEY = 64,
  localparam int KCW = $clog2(MAX_KEY + 1),
  localparam int KAW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [31:0]             hash,
  input  logic [KCW-1:0]          klen_in,
  input  logic                    ovf_in,
  input  logic [16:0]             db_length,
  input  logic                    wr_en,
  input  logic [15:0]             wr_addr,
  input  logic [7:0]              wr_data,
  output logic [KAW-1:0]          key_rd_idx,
  input  logic [7:0]              key_rd_data,
  input  logic                    out_free,
  output logic                    busy,
  output logic                    result_valid,
  output cdbl_pkg::result_t       result
);
  import cdbl_pkg::*;

  localparam int AW = (DB_BYTES > 1) ? $clog2(DB_BYTES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_TPOS, S_TLEN, S_TEND, S_DIV, S_SLOT,
    S_RPOS, S_SHASH, S_RKLEN, S_CMP, S_RLEN, S_NEXT, S_DONE
  } state_t;

  state_t state, ret;

  logic [7:0]       mem [DB_BYTES];
  logic [7:0]       rd_raw, rd_byte;
  logic             rd_ok;
  logic [XW-1:0]    rd_addr;
  logic [31:0]      ra32, wa32;

  logic [2:0]       fcnt;
  logic [XW-1:0]    fbase;
  logic [31:0]      word, h, tpos, tlen, rpos;
  logic [KCW-1:0]   klen, cnt;
  logic [LEN_W-1:0] maxv, maxr, max_clip, slot, start_slot, slot_inc;
  logic [XW-1:0]    sa, tend;
  logic             div_start, div_done;
  logic [16:0]      div_rem;

  // Image length clipped to the memory size.
  assign max_clip = (32'(db_length) > 32'(DB_BYTES)) ? LEN_W'(DB_BYTES) : db_length;

  assign sa       = XW'(tpos[16:0]) + XW'({slot, 3'b000});
  assign tend     = XW'(tpos[16:0]) + XW'({tlen[16:0], 3'b000});
  assign slot_inc = (slot + 17'd1 == tlen[16:0]) ? '0 : slot + 17'd1;

  // Read address: word fetches, or record key bytes during the compare.
  always_comb begin
    unique case (state)
      S_CMP:   rd_addr = XW'(rpos[16:0]) + XW'(8) + XW'(cnt);
      default: rd_addr = fbase + XW'(fcnt);
    endcase
  end

  assign ra32       = 32'(rd_addr);
  assign wa32       = {16'd0, wr_addr};
  assign key_rd_idx = cnt[KAW-1:0];

  // Database image memory: one write port for stores, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en && (wa32 < 32'(DB_BYTES))) begin
      mem[wa32[AW-1:0]] <= wr_data;
    end
    rd_raw <= mem[ra32[AW-1:0]];
    rd_ok  <= ra32 < 32'(DB_BYTES);
  end

  assign rd_byte = rd_ok ? rd_raw : 8'd0;

  assign div_start = (state == S_TEND) && !(tend > XW'(maxv));

  cdbl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (h[31:8]),
    .divisor  (tlen[16:0]),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Lookup sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            h                   <= hash;
            klen                <= klen_in;
            maxv                <= max_clip;
            result.value_offset <= '0;
            result.value_length <= '0;
            if (ovf_in) begin
              result.status <= ST_TOOLONG;
              state         <= S_DONE;
            end else if (max_clip < HEADER_BYTES ||
                         LEN_W'(klen_in) > max_clip - HEADER_BYTES) begin
              result.status <= ST_MISSING;
              state         <= S_DONE;
            end else begin
              fbase <= XW'({hash[7:0], 3'b000});
              fcnt  <= '0;
              ret   <= S_TPOS;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          // Little-endian assembly: each byte lands in the top and shifts down.
          if (fcnt != 3'd0) begin
            word <= {rd_byte, word[31:8]};
          end
          if (fcnt == 3'd4) begin
            state <= ret;
          end else begin
            fcnt <= fcnt + 3'd1;
          end
        end
        S_TPOS: begin
          tpos  <= word;
          fbase <= XW'({h[7:0], 3'b100});
          fcnt  <= '0;
          ret   <= S_TLEN;
          state <= S_FETCH;
        end
        S_TLEN: begin
          tlen <= word;
          if (word == 32'd0) begin
            result.status <= ST_MISSING;
            state         <= S_DONE;
          end else if (tpos > 32'(maxv) || word > 32'(maxv)) begin
            result.status <= ST_CORRUPT;
            state         <= S_DONE;
          end else begin
            state <= S_TEND;
          end
        end
        S_TEND: begin
          if (tend > XW'(maxv)) begin
            result.status <= ST_CORRUPT;
            state         <= S_DONE;
          end else begin
            maxr  <= maxv - LEN_W'(klen) - 17'd8;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            slot       <= div_rem;
            start_slot <= div_rem;
            state      <= S_SLOT;
          end
        end
        S_SLOT: begin
          fbase <= sa + XW'(4);
          fcnt  <= '0;
          ret   <= S_RPOS;
          state <= S_FETCH;
        end
        S_RPOS: begin
          rpos <= word;
          if (word == 32'd0) begin
            result.status <= ST_MISSING;
            state         <= S_DONE;
          end else begin
            fbase <= sa;
            fcnt  <= '0;
            ret   <= S_SHASH;
            state <= S_FETCH;
          end
        end
        S_SHASH: begin
          if (word == h) begin
            if (rpos > 32'(maxr)) begin
              result.status <= ST_CORRUPT;
              state         <= S_DONE;
            end else begin
              fbase <= XW'(rpos[16:0]);
              fcnt  <= '0;
              ret   <= S_RKLEN;
              state <= S_FETCH;
            end
          end else begin
            state <= S_NEXT;
          end
        end
        S_RKLEN: begin
          if (word != 32'(klen)) begin
            state <= S_NEXT;
          end else begin
            cnt   <= '0;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          // Byte i is issued while byte i-1 is checked.
          if (cnt != '0 && rd_byte != key_rd_data) begin
            state <= S_NEXT;
          end else if (cnt == klen) begin
            fbase <= XW'(rpos[16:0]) + XW'(4);
            fcnt  <= '0;
            ret   <= S_RLEN;
            state <= S_FETCH;
          end else begin
            cnt <= cnt + KCW'(1);
          end
        end
        S_RLEN: begin
          if (word <= 32'(maxr - rpos[16:0])) begin
            result.status       <= ST_FOUND;
            result.value_offset <= rpos[15:0] + 16'd8 + 16'(klen);
            result.value_length <= word[15:0];
          end else begin
            result.status <= ST_CORRUPT;
          end
          state <= S_DONE;
        end
        S_NEXT: begin
          slot <= slot_inc;
          if (slot_inc == start_slot) begin
            result.status <= ST_CORRUPT;
            state         <= S_DONE;
          end else begin
            state <= S_SLOT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign busy         = state != S_IDLE;
  assign result_valid = state == S_DONE;

  // Stores only land while no lookup walks the memory.
  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == S_IDLE) else $error("store during lookup");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> busy) else $error("lookup did not start");

  a_div_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> state == S_SLOT) else $error("divider result lost");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> state == S_IDLE) else $error("result not released");

endmodule
`default_nettype wire

// File: rtl/core/constant_database_key_lookup_unit.sv
`default_nettype none
// Constant-database key lookup.
// req carries items: store writes one image byte at address, append adds one
// key byte and advances the hash, lookup ends the key and searches the image.
// rsp carries one item per lookup: status, value offset and value length.
// cfg writes the image length register; write it only while the block is idle.
// Store and append items are taken whenever no lookup runs and give nothing
// on rsp. A lookup holds req.ready low while it runs. Each 32-bit word is
// read from the byte memory one byte at a time, and the start slot needs a
// 24-step divide. A lookup reads the header entry, divides, then probes the
// table; a slot whose hash or key length does not match is skipped, and a
// found record is compared byte by byte before its length is read, all
// via the single byte read port of the memory. The result passes through
// the rsp output register; overlong keys and failed length checks skip the
// table walk and go straight to the done state.
// Reset clears the key state and sets the image length to 2048; the image
// memory and key buffer keep no reset value and must be written before use.
// A finished result moves into the rsp register when it is free; while rsp is
// stalled, store and append items are still taken, and a further lookup runs
// but holds its result and req.ready low until the register drains.
module constant_database_key_lookup_unit #(
  parameter int DB_BYTES = 65536,
  parameter int MAX_KEY = 64
) (
  input  logic       clk,
  input  logic       rst,
  cdbl_req_if.sink   req,
  cdbl_rsp_if.source rsp,
  cdbl_cfg_if.sink   cfg
);
  import cdbl_pkg::*;

  localparam int KCW = $clog2(MAX_KEY + 1);
  localparam int KAW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

  logic             accept, do_store, do_append, do_lookup;
  logic             eng_busy, res_valid, out_free;
  result_t          res;
  logic [LEN_W-1:0] db_length;
  logic [KAW-1:0]   key_rd_idx;
  logic [7:0]       key_rd_data;
  logic [KCW-1:0]   key_count;
  logic             key_ovf;
  logic [31:0]      key_hash;

  assign req.ready = !eng_busy;
  assign accept    = req.valid && req.ready;
  assign do_store  = accept && req.action == ACT_STORE;
  assign do_append = accept && req.action == ACT_APPEND;
  assign do_lookup = accept && req.action == ACT_LOOKUP;

  // Image length register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      db_length <= LEN_RESET;
    end else if (cfg.valid) begin
      db_length <= cfg.data;
    end
  end

  cdbl_key #(.MAX_KEY(MAX_KEY)) u_key (
    .clk      (clk),
    .rst      (rst),
    .append   (do_append),
    .clear    (do_lookup),
    .byte_in  (req.data_byte),
    .rd_idx   (key_rd_idx),
    .rd_data  (key_rd_data),
    .count    (key_count),
    .overflow (key_ovf),
    .hash     (key_hash)
  );

  cdbl_engine #(.DB_BYTES(DB_BYTES), .MAX_KEY(MAX_KEY)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (do_lookup),
    .hash         (key_hash),
    .klen_in      (key_count),
    .ovf_in       (key_ovf),
    .db_length    (db_length),
    .wr_en        (do_store),
    .wr_addr      (req.address),
    .wr_data      (req.data_byte),
    .key_rd_idx   (key_rd_idx),
    .key_rd_data  (key_rd_data),
    .out_free     (out_free),
    .busy         (eng_busy),
    .result_valid (res_valid),
    .result       (res)
  );

  // Output register for the result item.
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && out_free) begin
      rsp.valid        <= 1'b1;
      rsp.status       <= res.status;
      rsp.value_offset <= res.value_offset;
      rsp.value_length <= res.value_length;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import cdbl_pkg::*;

  localparam int MEM_BYTES = 65536;
  localparam int KEY_MAX = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdbl_req_if req ();
  cdbl_rsp_if rsp ();
  cdbl_cfg_if cfg ();

  constant_database_key_lookup_unit #(
    .DB_BYTES(MEM_BYTES),
    .MAX_KEY(KEY_MAX)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the block's state, used to predict lookup answers.
  logic [7:0]  img [MEM_BYTES];
  bit          img_set [MEM_BYTES];
  logic [7:0]  key_bytes [KEY_MAX];
  int unsigned key_len;
  bit          key_ovf;
  logic [31:0] key_hash;
  logic [16:0] img_len;

  result_t     answers_due[$];
  int          errors = 0;
  int          lookups_seen = 0;
  int          sent_items = 0;
  int          status_hits [4];
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;
  int          hold_cycles = 0;

  // Table layout used by the generated images.
  logic [31:0] tbl_hash [$];
  int unsigned rec_klen [$];

  function automatic logic [31:0] rd_word(input int unsigned a);
    logic [31:0] w;
    w = 32'd0;
    for (int k = 0; k < 4; k++)
      if (a + k < MEM_BYTES) w[8*k +: 8] = img[a + k];
    return w;
  endfunction

  // Walks the hash table exactly as the block does and returns its answer.
  function automatic result_t search_image();
    result_t r;
    logic [31:0] h, tpos, tlen, tend, slot, start, sa, rpos, rlen, lim;
    bit same;
    r.status = ST_MISSING;
    r.value_offset = 16'd0;
    r.value_length = 16'd0;
    if (key_ovf) begin
      r.status = ST_TOOLONG;
      return r;
    end
    h = key_hash;
    lim = (img_len > MEM_BYTES) ? MEM_BYTES : img_len;
    if (lim < 2048) return r;
    if (key_len > lim - 2048) return r;
    tpos = rd_word((h & 32'hff) << 3);
    tlen = rd_word(((h & 32'hff) << 3) + 4);
    if (tlen == 0) return r;
    r.status = ST_CORRUPT;
    if (tpos > lim || tlen > lim) return r;
    tend = tpos + (tlen << 3);
    if (tend > lim || tend < tpos || tlen != ((tend - tpos) >> 3)) return r;
    start = (h >> 8) % tlen;
    slot = start;
    lim = lim - (key_len + 8);
    do begin
      sa = tpos + (slot << 3);
      rpos = rd_word(sa + 4);
      if (rpos == 0) begin
        r.status = ST_MISSING;
        return r;
      end
      if (rd_word(sa) == h) begin
        if (rpos > lim) return r;
        same = (rd_word(rpos) == key_len);
        for (int unsigned i = 0; same && i < key_len; i++)
          if (img[rpos + 8 + i] != key_bytes[i]) same = 1'b0;
        if (same) begin
          rlen = rd_word(rpos + 4);
          if (rlen <= lim - rpos) begin
            r.status = ST_FOUND;
            r.value_offset = 16'(rpos + 8 + key_len);
            r.value_length = 16'(rlen);
          end
          return r;
        end
      end
      slot = slot + 1;
      if (slot == tlen) slot = 0;
    end while (slot != start);
    return r;
  endfunction

  // Updates the shadow state for one accepted item.
  task automatic predict_item(input logic [1:0] act, input logic [15:0] adr,
                              input logic [7:0] dat);
    if (act == ACT_STORE) begin
      img[adr] = dat;
      img_set[adr] = 1'b1;
    end else if (act == ACT_APPEND) begin
      if (key_len < KEY_MAX) begin
        key_bytes[key_len] = dat;
        key_len++;
        key_hash = (key_hash * 33) ^ {24'd0, dat};
      end else begin
        key_ovf = 1'b1;
      end
    end else if (act == ACT_LOOKUP) begin
      answers_due.push_back(search_image());
      key_len = 0;
      key_ovf = 1'b0;
      key_hash = HASH_START;
    end
  endtask

  // Sends one item, idling at random beforehand.
  task automatic send_item(input logic [1:0] act, input logic [15:0] adr,
                           input logic [7:0] dat);
    while (!sender_calm && $urandom_range(99) < 34) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.address <= adr;
    req.data_byte <= dat;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_item(act, adr, dat);
    sent_items++;
  endtask

  task automatic go_idle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    // A lookup that has no answer yet is covered by the answer count;
    // stores may still be in flight.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_len(input logic [16:0] v);
    go_idle();
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    img_len = v;
  endtask

  task automatic store_word(input int unsigned a, input logic [31:0] w);
    for (int k = 0; k < 4; k++) send_item(ACT_STORE, 16'(a + k), w[8*k +: 8]);
  endtask

  function automatic logic [31:0] hash_of(input logic [7:0] kb[$]);
    logic [31:0] h;
    h = HASH_START;
    foreach (kb[i]) h = (h * 33) ^ {24'd0, kb[i]};
    return h;
  endfunction

  // Zeroes any unwritten byte of the header entry that a hash selects, so
  // the lookup only reads written bytes.
  task automatic ensure_header(input logic [31:0] h);
    int unsigned a;
    a = (h & 32'hff) * 8;
    for (int unsigned k = 0; k < 8; k++)
      if (!img_set[a + k]) send_item(ACT_STORE, 16'(a + k), 8'd0);
  endtask

  task automatic send_key(input logic [7:0] kb[$]);
    if (kb.size() <= KEY_MAX) ensure_header(hash_of(kb));
    foreach (kb[i]) send_item(ACT_APPEND, 16'($urandom), kb[i]);
    send_item(ACT_LOOKUP, 16'($urandom), 8'($urandom));
  endtask

  // Builds one table of 'n' slots at 'tpos' for the given header entry and
  // places records for the given keys at their hash slot or the next free one.
  task automatic build_table(input int unsigned hidx, input int unsigned tpos,
                             input int unsigned n, input logic [7:0] k0[$],
                             input logic [7:0] k1[$], inout int unsigned heap);
    logic [31:0] h;
    int unsigned s;
    logic [7:0] kk[$];
    store_word(hidx * 8, tpos);
    store_word(hidx * 8 + 4, n);
    for (int unsigned i = 0; i < n; i++) begin
      store_word(tpos + 8 * i, 32'($urandom));
      store_word(tpos + 8 * i + 4, 32'd0);
    end
    for (int j = 0; j < 2; j++) begin
      if (j == 0) kk = k0;
      else kk = k1;
      h = hash_of(kk);
      s = (h >> 8) % n;
      while (rd_word(tpos + 8 * s + 4) != 0) s = (s + 1) % n;
      store_word(tpos + 8 * s, h);
      store_word(tpos + 8 * s + 4, heap);
      store_word(heap, kk.size());
      store_word(heap + 4, 32'($urandom_range(6)));
      foreach (kk[i]) send_item(ACT_STORE, 16'(heap + 8 + i), kk[i]);
      heap = heap + 8 + kk.size() + 8;
    end
  endtask

  function automatic void rand_key(ref logic [7:0] kb[$], input int unsigned n);
    kb.delete();
    for (int unsigned i = 0; i < n; i++) kb.push_back(8'($urandom));
  endfunction

  // Builds a small image with two keys in one table and looks them up.
  task automatic run_image_round(input bit with_noise);
    logic [7:0] ka[$], kb[$], kc[$];
    int unsigned heap, tp, n;
    rand_key(ka, $urandom_range(0, 6));
    rand_key(kb, $urandom_range(1, 6));
    if ((hash_of(ka) & 32'hff) != (hash_of(kb) & 32'hff)) kb = ka;
    tp = 2048 + 8 * $urandom_range(0, 8);
    n = $urandom_range(2, 4);
    heap = tp + 8 * n;
    build_table(hash_of(ka) & 32'hff, tp, n, ka, kb, heap);
    store_word(heap, 0);
    send_key(ka);
    send_key(kb);
    if (with_noise) begin
      // Miss in the same table if its header matches, else ka again.
      kc = ka;
      kc.push_back(8'($urandom));
      if ((hash_of(kc) & 32'hff) == (hash_of(ka) & 32'hff)) send_key(kc);
      else send_key(ka);
      // Unknown action does nothing.
      send_item(2'd3, 16'($urandom), 8'($urandom));
      // A corrupted record length, at random.
      if ($urandom_range(1)) begin
        store_word(heap - 8 - kb.size() - 8 + 4, 32'hffff_ff00);
        send_key(kb);
      end
    end
    // Undo the header entry so later rounds start clean.
    store_word((hash_of(ka) & 32'hff) * 8 + 4, 32'd0);
  endtask

  // Directed cases: extremes of each field, every action and special case.
  task automatic test_directed();
    logic [7:0] kb[$];
    write_len(17'd4096);
    // Empty table.
    kb = {8'h00};
    send_key(kb);
    kb = {8'hff, 8'h80};
    send_key(kb);
    // Empty key, empty table.
    kb.delete();
    send_key(kb);
    // Store to the last address and an unknown action.
    send_item(ACT_STORE, 16'hffff, 8'hff);
    send_item(2'd3, 16'hffff, 8'hff);
    // Key too long.
    rand_key(kb, KEY_MAX + 2);
    send_key(kb);
    // Full key length exactly.
    rand_key(kb, KEY_MAX);
    send_key(kb);
    run_image_round(1'b1);
    // Table outside the image.
    kb = {8'h5a};
    store_word((hash_of(kb) & 32'hff) * 8, 32'd4090);
    store_word((hash_of(kb) & 32'hff) * 8 + 4, 32'd3);
    send_key(kb);
    store_word((hash_of(kb) & 32'hff) * 8 + 4, 32'd0);
    // Short image and key longer than image.
    write_len(17'd0);
    send_key(kb);
    write_len(17'd2048);
    send_key(kb);
    kb.delete();
    send_key(kb);
    // Long image is clamped.
    write_len(17'h1ffff);
    send_key(kb);
  endtask

  // Mostly well formed images and keys with some random noise items.
  task automatic test_random();
    logic [7:0] kb[$];
    write_len(17'd4096);
    while (sent_items < 1400 + 2200 * 0 && lookups_seen < 10000) begin
      if ($urandom_range(9) < 8) begin
        run_image_round($urandom_range(1));
      end else begin
        rand_key(kb, $urandom_range(0, 3) == 0 ? KEY_MAX + 1 : $urandom_range(0, 5));
        send_key(kb);
      end
      if (sent_items > 9000) break;
    end
  endtask

  // Pressure and a calm stretch: receiver holds off while items keep coming.
  task automatic test_backpressure();
    logic [7:0] kb[$];
    sender_calm = 1'b1;
    receiver_calm = 1'b1;
    hold_cycles = 300;
    for (int i = 0; i < 6; i++) begin
      rand_key(kb, $urandom_range(0, 3));
      send_key(kb);
    end
    run_image_round(1'b0);
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    write_len(17'd65535);
    run_image_round(1'b1);
  endtask

  // Receiver: random stalls, an optional long hold-off counted in cycles.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= receiver_calm || ($urandom_range(99) >= 34);
    end
  end

  // Checks each accepted answer against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected answer status=%0d off=%0d len=%0d", $time,
                 rsp.status, rsp.value_offset, rsp.value_length);
        errors++;
      end else begin
        want = answers_due.pop_front();
        lookups_seen++;
        status_hits[want.status]++;
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
          errors++;
        end
        if (rsp.value_offset !== want.value_offset) begin
          $display("%0t: value_offset expected %0d actual %0d", $time,
                   want.value_offset, rsp.value_offset);
          errors++;
        end
        if (rsp.value_length !== want.value_length) begin
          $display("%0t: value_length expected %0d actual %0d", $time,
                   want.value_length, rsp.value_length);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #400ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int spin;
    req.valid = 1'b0;
    req.action = ACT_STORE;
    req.address = '0;
    req.data_byte = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    key_len = 0;
    key_ovf = 1'b0;
    key_hash = HASH_START;
    img_len = LEN_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    req.valid <= 1'b0;
    spin = 0;
    while (answers_due.size() != 0 && spin < 100000) begin
      @(posedge clk);
      spin++;
    end
    repeat (200) @(posedge clk);
    $display("Covered %0d items and %0d lookups: found %0d, missing %0d,",
             sent_items, lookups_seen, status_hits[0], status_hits[1]);
    $display("corrupt %0d, key too long %0d.", status_hits[2], status_hits[3]);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: constant_database_key_lookup_unit.f
rtl/core/cdbl_pkg.sv
rtl/core/cdbl_ifs.sv
rtl/core/cdbl_div.sv
rtl/core/cdbl_key.sv
rtl/core/cdbl_engine.sv
rtl/core/constant_database_key_lookup_unit.sv
test/tb_top.sv
